// ===== sv/tmrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmrq_pkg
// shared widths, types and the control word for the tetrahedron quality pipe
// ----------------------------------------------------------------------------
`default_nettype none

package tmrq_pkg;

  // coordinate width and output format
  localparam int CB   = 24;
  localparam int FRAC = 16;
  localparam int OW   = 32;

  // edge columns a, b, c and their products
  localparam int CW   = CB + 4;
  localparam int PW   = 2 * CW;
  localparam int CFW  = PW + 1;
  localparam int LOW  = CW + 1;
  localparam int HIW  = CFW - LOW;
  localparam int PLW  = CW + LOW + 1;
  localparam int PHW  = CW + HIW;
  localparam int TW   = CW + CFW + 3;

  // determinant magnitude, split in three limbs
  localparam int DL   = CW;
  localparam int DMW  = 3 * DL;
  localparam int D2W  = 2 * DMW;
  localparam int GDW  = 2 * DL + 2;
  localparam int EW   = D2W + 9;

  // weighted norm, split in two limbs
  localparam int NL   = CW + 2;
  localparam int NW   = 2 * NL;
  localparam int N2W  = 4 * NL;
  localparam int N3W  = 6 * NL;
  localparam int GNW  = 2 * NL + 2;

  // quotient, cube root
  localparam int QW   = 3 * OW;
  localparam int SH   = QW - 3 * FRAC;
  localparam int CMW  = EW + N3W;
  localparam int UW   = 2 * OW + 2;
  localparam int WW   = OW + 2;
  localparam int CRW  = 2 * OW + 6;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    logic vld;
    logic zero;
    logic sat;
  } ctl_t;

endpackage

`default_nettype wire

// ===== sv/tmrq_if.sv =====
// ----------------------------------------------------------------------------
// tmrq_if
// request channels: tetrahedron vertices in, quality result out
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrq_tet_if;
  logic valid;
  logic ready;
  tmrq_pkg::coord_t v0_x, v0_y, v0_z;
  tmrq_pkg::coord_t v1_x, v1_y, v1_z;
  tmrq_pkg::coord_t v2_x, v2_y, v2_z;
  tmrq_pkg::coord_t v3_x, v3_y, v3_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
           v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
           v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
    output ready
  );
endinterface

interface tmrq_qual_if;
  logic                      valid;
  logic                      ready;
  logic [tmrq_pkg::OW-1:0]   inv_mean_ratio;
  logic                      degenerate;

  modport source (output valid, inv_mean_ratio, degenerate, input ready);
  modport sink (input valid, inv_mean_ratio, degenerate, output ready);
endinterface

`default_nettype wire

// ===== sv/tmrq_geom.sv =====
// ----------------------------------------------------------------------------
// tmrq_geom
// edge columns, determinant magnitude and weighted norm, seven stages
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_geom (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vld_in,
  input  tmrq_pkg::coord_t            vtx [4][3],
  output tmrq_pkg::ctl_t              ctl_out,
  output logic [tmrq_pkg::DMW-1:0]    dmag,
  output logic [tmrq_pkg::NW-1:0]     nrm
);

  localparam int CB  = tmrq_pkg::CB;
  localparam int CW  = tmrq_pkg::CW;
  localparam int PW  = tmrq_pkg::PW;
  localparam int CFW = tmrq_pkg::CFW;
  localparam int LOW = tmrq_pkg::LOW;
  localparam int PLW = tmrq_pkg::PLW;
  localparam int PHW = tmrq_pkg::PHW;
  localparam int TW  = tmrq_pkg::TW;
  localparam int NW  = tmrq_pkg::NW;
  localparam int DMW = tmrq_pkg::DMW;

  logic signed [CW-1:0]  xe [4][3];
  logic signed [CW-1:0]  a_n [3];
  logic signed [CW-1:0]  b_n [3];
  logic signed [CW-1:0]  c_n [3];

  logic [5:0]            vld;
  tmrq_pkg::ctl_t        ctl7;

  logic signed [CW-1:0]  a1 [3];
  logic signed [CW-1:0]  b1 [3];
  logic signed [CW-1:0]  c1 [3];
  logic signed [PW-1:0]  pp2 [3];
  logic signed [PW-1:0]  pm2 [3];
  logic signed [PW-1:0]  sqa2 [3];
  logic signed [PW-1:0]  sqb2 [3];
  logic signed [PW-1:0]  sqc2 [3];
  logic signed [CW-1:0]  a2 [3];
  logic signed [CFW-1:0] cof3 [3];
  logic signed [CW-1:0]  a3 [3];
  logic [NW-1:0]         sa3, sb3, sc3;
  logic signed [PLW-1:0] lo4 [3];
  logic signed [PHW-1:0] hi4 [3];
  logic [NW-1:0]         nrm4, nrm5, nrm6, nrm7;
  logic signed [TW-1:0]  t5 [3];
  logic signed [TW-1:0]  d6;
  logic signed [TW-1:0]  d_abs;
  logic [DMW-1:0]        dmag7;

  // sign extend coordinates and form the three integer columns
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        xe[k][r] = {{(CW-CB){vtx[k][r][CB-1]}}, vtx[k][r]};
      end
    end
    for (int r = 0; r < 3; r++) begin
      a_n[r] = xe[1][r] - xe[0][r];
      b_n[r] = (xe[2][r] <<< 1) - xe[1][r] - xe[0][r];
      c_n[r] = (xe[3][r] <<< 1) + xe[3][r] - xe[2][r] - xe[1][r] - xe[0][r];
    end
  end

  assign d_abs = d6[TW-1] ? -d6 : d6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ctl7 <= '0;
    end else if (en) begin
      vld  <= {vld[4:0], vld_in};
      ctl7 <= '{vld: vld[5], zero: (d6 == '0), sat: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // columns
      for (int r = 0; r < 3; r++) begin
        a1[r] <= a_n[r];
        b1[r] <= b_n[r];
        c1[r] <= c_n[r];
      end
      // cofactor products and squares
      pp2[0] <= b1[1] * c1[2];
      pm2[0] <= b1[2] * c1[1];
      pp2[1] <= b1[2] * c1[0];
      pm2[1] <= b1[0] * c1[2];
      pp2[2] <= b1[0] * c1[1];
      pm2[2] <= b1[1] * c1[0];
      for (int r = 0; r < 3; r++) begin
        sqa2[r] <= a1[r] * a1[r];
        sqb2[r] <= b1[r] * b1[r];
        sqc2[r] <= c1[r] * c1[r];
        a2[r]   <= a1[r];
      end
      // cofactors and squared column lengths
      for (int r = 0; r < 3; r++) begin
        cof3[r] <= CFW'(pp2[r]) - CFW'(pm2[r]);
        a3[r]   <= a2[r];
      end
      sa3 <= NW'(sqa2[0]) + NW'(sqa2[1]) + NW'(sqa2[2]);
      sb3 <= NW'(sqb2[0]) + NW'(sqb2[1]) + NW'(sqb2[2]);
      sc3 <= NW'(sqc2[0]) + NW'(sqc2[1]) + NW'(sqc2[2]);
      // cofactor times a, split in high and low halves
      for (int r = 0; r < 3; r++) begin
        lo4[r] <= a3[r] * $signed({1'b0, cof3[r][LOW-1:0]});
        hi4[r] <= a3[r] * $signed(cof3[r][CFW-1:LOW]);
      end
      nrm4 <= (sa3 << 2) + (sa3 << 1) + (sb3 << 1) + sc3;
      // join halves
      for (int r = 0; r < 3; r++) begin
        t5[r] <= (TW'(hi4[r]) <<< LOW) + TW'(lo4[r]);
      end
      nrm5 <= nrm4;
      // determinant
      d6    <= t5[0] + t5[1] + t5[2];
      nrm6  <= nrm5;
      // magnitude
      dmag7 <= d_abs[DMW-1:0];
      nrm7  <= nrm6;
    end
  end

  assign ctl_out = ctl7;
  assign dmag    = dmag7;
  assign nrm     = nrm7;

endmodule

`default_nettype wire

// ===== sv/tmrq_scale.sv =====
// ----------------------------------------------------------------------------
// tmrq_scale
// 324*D^2 and N^3 by limb products, saturation test, divider seed
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tmrq_pkg::ctl_t              ctl_in,
  input  logic [tmrq_pkg::DMW-1:0]    dmag,
  input  logic [tmrq_pkg::NW-1:0]     nrm,
  output tmrq_pkg::ctl_t              ctl_out,
  output logic [tmrq_pkg::EW-1:0]     e_out,
  output logic [tmrq_pkg::EW-1:0]     rem_out,
  output logic [tmrq_pkg::QW-1:0]     bits_out
);

  localparam int DL   = tmrq_pkg::DL;
  localparam int D2W  = tmrq_pkg::D2W;
  localparam int GDW  = tmrq_pkg::GDW;
  localparam int EW   = tmrq_pkg::EW;
  localparam int NL   = tmrq_pkg::NL;
  localparam int NW   = tmrq_pkg::NW;
  localparam int N2W  = tmrq_pkg::N2W;
  localparam int N3W  = tmrq_pkg::N3W;
  localparam int GNW  = tmrq_pkg::GNW;
  localparam int SH   = tmrq_pkg::SH;
  localparam int CMW  = tmrq_pkg::CMW;
  localparam int QW   = tmrq_pkg::QW;
  localparam int FZ   = 3 * tmrq_pkg::FRAC;

  tmrq_pkg::ctl_t        c1, c2, c3, c4, c5, c6, c7;

  logic [2*DL-1:0]       pd1 [3][3];
  logic [2*NL-1:0]       pn1 [2][2];
  logic [NW-1:0]         n1, n2, n3;
  logic [GDW-1:0]        gd2 [5];
  logic [GNW-1:0]        gn2 [3];
  logic [D2W-1:0]        d2_3, d2_sum;
  logic [N2W-1:0]        n2_3, n2_sum;
  logic [EW-1:0]         e4, e5, e6, e7;
  logic [2*NL-1:0]       pr4 [4][2];
  logic [GNW-1:0]        gr5 [5];
  logic [N3W-1:0]        n3_6, n3_sum;
  logic [N3W-SH-1:0]     top6;
  logic                  sat7;
  logic [EW-1:0]         rem7;
  logic [QW-1:0]         bits7;

  // shifted limb sums
  always_comb begin
    d2_sum = '0;
    for (int k = 0; k < 5; k++) begin
      d2_sum = d2_sum + (D2W'(gd2[k]) << (DL * k));
    end
    n2_sum = '0;
    for (int k = 0; k < 3; k++) begin
      n2_sum = n2_sum + (N2W'(gn2[k]) << (NL * k));
    end
    n3_sum = '0;
    for (int k = 0; k < 5; k++) begin
      n3_sum = n3_sum + (N3W'(gr5[k]) << (NL * k));
    end
  end

  assign top6 = n3_6[N3W-1:SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
      c7 <= '0;
    end else if (en) begin
      c1 <= ctl_in;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      c6 <= c5;
      c7 <= '{vld: c6.vld, zero: c6.zero, sat: (CMW'(top6) >= CMW'(e6))};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // limb partial products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pd1[i][j] <= dmag[i*DL +: DL] * dmag[j*DL +: DL];
        end
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          pn1[i][j] <= nrm[i*NL +: NL] * nrm[j*NL +: NL];
        end
      end
      n1 <= nrm;
      // column sums of equal weight
      gd2[0] <= GDW'(pd1[0][0]);
      gd2[1] <= GDW'(pd1[0][1]) + GDW'(pd1[1][0]);
      gd2[2] <= GDW'(pd1[0][2]) + GDW'(pd1[1][1]) + GDW'(pd1[2][0]);
      gd2[3] <= GDW'(pd1[1][2]) + GDW'(pd1[2][1]);
      gd2[4] <= GDW'(pd1[2][2]);
      gn2[0] <= GNW'(pn1[0][0]);
      gn2[1] <= GNW'(pn1[0][1]) + GNW'(pn1[1][0]);
      gn2[2] <= GNW'(pn1[1][1]);
      n2 <= n1;
      // D^2 and N^2
      d2_3 <= d2_sum;
      n2_3 <= n2_sum;
      n3   <= n2;
      // 324 = 256 + 64 + 4, and N^2 * N partials
      e4 <= (EW'(d2_3) << 8) + (EW'(d2_3) << 6) + (EW'(d2_3) << 2);
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pr4[i][j] <= n2_3[i*NL +: NL] * n3[j*NL +: NL];
        end
      end
      e5 <= e4;
      gr5[0] <= GNW'(pr4[0][0]);
      gr5[1] <= GNW'(pr4[1][0]) + GNW'(pr4[0][1]);
      gr5[2] <= GNW'(pr4[2][0]) + GNW'(pr4[1][1]);
      gr5[3] <= GNW'(pr4[3][0]) + GNW'(pr4[2][1]);
      gr5[4] <= GNW'(pr4[3][1]);
      // N^3
      e6   <= e5;
      n3_6 <= n3_sum;
      // dividend is N^3 shifted up by the output fraction, cubed
      e7    <= e6;
      rem7  <= EW'(top6);
      bits7 <= {n3_6[SH-1:0], {FZ{1'b0}}};
    end
  end

  assign sat7     = c7.sat;
  assign ctl_out  = '{vld: c7.vld, zero: c7.zero, sat: sat7};
  assign e_out    = e7;
  assign rem_out  = rem7;
  assign bits_out = bits7;

endmodule

`default_nettype wire

// ===== sv/tmrq_div_step.sv =====
// ----------------------------------------------------------------------------
// tmrq_div_step
// one restoring division stage, one quotient bit
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_div_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tmrq_pkg::ctl_t              ctl_in,
  input  logic [tmrq_pkg::EW-1:0]     e_in,
  input  logic [tmrq_pkg::EW-1:0]     rem_in,
  input  logic [tmrq_pkg::QW-1:0]     bits_in,
  output tmrq_pkg::ctl_t              ctl_out,
  output logic [tmrq_pkg::EW-1:0]     e_out,
  output logic [tmrq_pkg::EW-1:0]     rem_out,
  output logic [tmrq_pkg::QW-1:0]     bits_out
);

  localparam int EW = tmrq_pkg::EW;
  localparam int QW = tmrq_pkg::QW;

  logic [EW:0]   t;
  logic [EW+1:0] diff;
  logic          ge;

  // bring down the next dividend bit and trial subtract
  assign t    = {rem_in, bits_in[QW-1]};
  assign diff = {1'b0, t} - {2'b00, e_in};
  assign ge   = ~diff[EW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_out    <= e_in;
      rem_out  <= ge ? diff[EW-1:0] : t[EW-1:0];
      bits_out <= {bits_in[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmrq_cbrt_step.sv =====
// ----------------------------------------------------------------------------
// tmrq_cbrt_step
// one digit-by-digit cube root stage, one root bit from three radicand bits
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_cbrt_step (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  tmrq_pkg::ctl_t              ctl_in,
  input  logic [tmrq_pkg::QW-1:0]     q_in,
  input  logic [tmrq_pkg::OW-1:0]     y_in,
  input  logic [tmrq_pkg::UW-1:0]     u_in,
  input  logic [tmrq_pkg::WW-1:0]     w_in,
  input  logic [tmrq_pkg::CRW-1:0]    r_in,
  output tmrq_pkg::ctl_t              ctl_out,
  output logic [tmrq_pkg::QW-1:0]     q_out,
  output logic [tmrq_pkg::OW-1:0]     y_out,
  output logic [tmrq_pkg::UW-1:0]     u_out,
  output logic [tmrq_pkg::WW-1:0]     w_out,
  output logic [tmrq_pkg::CRW-1:0]    r_out
);

  localparam int QW  = tmrq_pkg::QW;
  localparam int OW  = tmrq_pkg::OW;
  localparam int UW  = tmrq_pkg::UW;
  localparam int WW  = tmrq_pkg::WW;
  localparam int CRW = tmrq_pkg::CRW;

  logic [CRW-1:0] t;
  logic [CRW-1:0] b;
  logic [CRW:0]   diff;
  logic           ge;

  // u = 3*y^2 and w = 3*y, so the trial term 3*y'^2 + 3*y' + 1 with y' = 2y
  // is 4u + 2w + 1
  assign t    = {r_in[CRW-4:0], q_in[QW-1 -: 3]};
  assign b    = CRW'({u_in, 2'b00}) + CRW'({w_in, 1'b1});
  assign diff = {1'b0, t} - {1'b0, b};
  assign ge   = ~diff[CRW];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out <= {q_in[QW-4:0], 3'b000};
      y_out <= {y_in[OW-2:0], ge};
      r_out <= ge ? diff[CRW-1:0] : t;
      if (ge) begin
        u_out <= UW'({u_in, 2'b00}) + UW'({w_in, 2'b00}) + UW'(3);
        w_out <= WW'({w_in, 1'b0}) + WW'(3);
      end else begin
        u_out <= UW'({u_in, 2'b00});
        w_out <= WW'({w_in, 1'b0});
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tetra_mean_ratio_quality.sv =====
// ----------------------------------------------------------------------------
// tetra_mean_ratio_quality
// inverse mean ratio of a tetrahedron from four integer vertices, Q16.16
// ----------------------------------------------------------------------------
// One tetrahedron request per clock goes in and one result per clock comes
// out while the pipe is not held; a request passes 143 register stages to
// the result on the output register, the first loading at the accepting
// edge: 7 geometry, 7 scaling, 96 divider, 32 cube root, 1 output. The
// whole pipe advances together; it holds only while a finished result sits
// on the output and the consumer does not take it, and input ready is low in
// exactly those cycles.
// The result is exact: with integer columns a = v1-v0, b = 2v2-v1-v0,
// c = 3v3-v2-v1-v0, D = det[a b c] and N = 6|a|^2 + 2|b|^2 + |c|^2, the
// output is the largest R with R^3 * 324 * D^2 <= N^3 * 2^48, i.e. the
// quality truncated toward zero. A flat cell (D = 0) or a result of 2^32 or
// more gives all ones with degenerate set. Mirror images give equal results.
// ----------------------------------------------------------------------------
`default_nettype none

module tetra_mean_ratio_quality (
  input  logic               clk,
  input  logic               rst,
  tmrq_tet_if.sink           tet,
  tmrq_qual_if.source        qual
);

  localparam int EW  = tmrq_pkg::EW;
  localparam int QW  = tmrq_pkg::QW;
  localparam int OW  = tmrq_pkg::OW;
  localparam int UW  = tmrq_pkg::UW;
  localparam int WW  = tmrq_pkg::WW;
  localparam int CRW = tmrq_pkg::CRW;

  // global advance: the pipe moves unless the output register is stuck
  logic                       en;

  tmrq_pkg::coord_t           vtx [4][3];

  // geometry to scaling
  tmrq_pkg::ctl_t             g_ctl;
  logic [tmrq_pkg::DMW-1:0]   g_dmag;
  logic [tmrq_pkg::NW-1:0]    g_nrm;

  // divider chain, index 0 is the seed from the scaling stages
  tmrq_pkg::ctl_t             d_ctl  [QW+1];
  logic [EW-1:0]              d_e    [QW+1];
  logic [EW-1:0]              d_rem  [QW+1];
  logic [QW-1:0]              d_bits [QW+1];

  // cube root chain, index 0 takes the quotient
  tmrq_pkg::ctl_t             c_ctl  [OW+1];
  logic [QW-1:0]              c_q    [OW+1];
  logic [OW-1:0]              c_y    [OW+1];
  logic [UW-1:0]              c_u    [OW+1];
  logic [WW-1:0]              c_w    [OW+1];
  logic [CRW-1:0]             c_r    [OW+1];

  // output register
  logic                       o_vld;
  logic [OW-1:0]              o_res;
  logic                       o_deg;

  assign en        = ~o_vld | qual.ready;
  assign tet.ready = en;

  // vertex fields by vertex, then axis
  assign vtx[0][0] = tet.v0_x;
  assign vtx[0][1] = tet.v0_y;
  assign vtx[0][2] = tet.v0_z;
  assign vtx[1][0] = tet.v1_x;
  assign vtx[1][1] = tet.v1_y;
  assign vtx[1][2] = tet.v1_z;
  assign vtx[2][0] = tet.v2_x;
  assign vtx[2][1] = tet.v2_y;
  assign vtx[2][2] = tet.v2_z;
  assign vtx[3][0] = tet.v3_x;
  assign vtx[3][1] = tet.v3_y;
  assign vtx[3][2] = tet.v3_z;

  // columns, |D| and N
  tmrq_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (tet.valid),
    .vtx     (vtx),
    .ctl_out (g_ctl),
    .dmag    (g_dmag),
    .nrm     (g_nrm)
  );

  // divisor 324*D^2, dividend N^3 * 2^48, overflow of the quotient
  tmrq_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (g_ctl),
    .dmag     (g_dmag),
    .nrm      (g_nrm),
    .ctl_out  (d_ctl[0]),
    .e_out    (d_e[0]),
    .rem_out  (d_rem[0]),
    .bits_out (d_bits[0])
  );

  // quotient, one bit per stage; below saturation it fits in 96 bits
  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    tmrq_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (d_ctl[gi]),
      .e_in     (d_e[gi]),
      .rem_in   (d_rem[gi]),
      .bits_in  (d_bits[gi]),
      .ctl_out  (d_ctl[gi+1]),
      .e_out    (d_e[gi+1]),
      .rem_out  (d_rem[gi+1]),
      .bits_out (d_bits[gi+1])
    );
  end

  // integer cube root of the quotient, root starts at zero
  assign c_ctl[0] = d_ctl[QW];
  assign c_q[0]   = d_bits[QW];
  assign c_y[0]   = '0;
  assign c_u[0]   = '0;
  assign c_w[0]   = '0;
  assign c_r[0]   = '0;

  for (genvar gi = 0; gi < OW; gi++) begin : g_cbrt
    tmrq_cbrt_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (c_ctl[gi]),
      .q_in    (c_q[gi]),
      .y_in    (c_y[gi]),
      .u_in    (c_u[gi]),
      .w_in    (c_w[gi]),
      .r_in    (c_r[gi]),
      .ctl_out (c_ctl[gi+1]),
      .q_out   (c_q[gi+1]),
      .y_out   (c_y[gi+1]),
      .u_out   (c_u[gi+1]),
      .w_out   (c_w[gi+1]),
      .r_out   (c_r[gi+1])
    );
  end

  // flat or saturated cells give all ones with the flag set
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= c_ctl[OW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_ctl[OW].zero || c_ctl[OW].sat) begin
        o_res <= '1;
        o_deg <= 1'b1;
      end else begin
        o_res <= c_y[OW];
        o_deg <= 1'b0;
      end
    end
  end

  assign qual.valid          = o_vld;
  assign qual.inv_mean_ratio = o_res;
  assign qual.degenerate     = o_deg;

endmodule

`default_nettype wire
